FILE: rtl/rtpk_pkg.sv
package rtpk_pkg;

  localparam int unsigned FRAG_SIZE   = 1400;
  localparam int unsigned MAX_NAL_LEN = 65535;

  localparam int unsigned LEN_W  = 16;
  localparam int unsigned PLEN_W = 11;
  localparam int unsigned TS_W   = 32;
  localparam int unsigned SEQ_W  = 16;
  localparam int unsigned CFG_W  = 32;
  localparam int unsigned IDX_W  = 2;

  localparam int unsigned S_DATA_W = 24;
  localparam int unsigned M_DATA_W = 104;

  localparam logic [4:0]        FU_A_TYPE      = 5'd28;
  localparam logic [PLEN_W-1:0] HDR_LEN_SINGLE = 11'd12;
  localparam logic [PLEN_W-1:0] HDR_LEN_FU_A   = 11'd14;
  localparam logic [TS_W-1:0]   TS_INC_RESET   = 32'd3000;

  localparam logic [IDX_W-1:0] REG_TS_INCREMENT = 2'd0;
  localparam logic [IDX_W-1:0] REG_PAYLOAD_TYPE = 2'd1;
  localparam logic [IDX_W-1:0] REG_SSRC         = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  typedef struct packed {
    logic load;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
  } dp_status_t;

endpackage

FILE: rtl/rtpk_ctrl.sv
module rtpk_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  rtpk_pkg::dp_status_t status,
  output rtpk_pkg::dp_cmd_t    cmd
);
  import rtpk_pkg::*;

  state_t state;
  state_t state_next;
  logic   m_tvalid_next;

  assign s_tready = (state == ST_IDLE);
  assign cmd.load = s_tvalid && s_tready;
  assign cmd.emit = (state == ST_RUN) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.load) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (cmd.emit && status.done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    m_tvalid_next = m_tvalid;
    if (cmd.emit) m_tvalid_next = 1'b1;
    else if (m_tready) m_tvalid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

FILE: rtl/rtpk_datapath.sv
module rtpk_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [rtpk_pkg::S_DATA_W-1:0]       s_tdata,
  input  logic                                cfg_we,
  input  logic [rtpk_pkg::IDX_W-1:0]          cfg_index,
  input  logic [rtpk_pkg::CFG_W-1:0]          cfg_data,
  input  rtpk_pkg::dp_cmd_t                   cmd,
  output rtpk_pkg::dp_status_t                status,
  output logic [rtpk_pkg::M_DATA_W-1:0]       m_tdata,
  output logic                                m_tuser,
  output logic                                m_tlast
);
  import rtpk_pkg::*;

  localparam logic [LEN_W-1:0]  FRAG_LEN  = LEN_W'(FRAG_SIZE);
  localparam logic [PLEN_W-1:0] FRAG_PLEN = PLEN_W'(FRAG_SIZE);

  logic [TS_W-1:0]  ts_increment;
  logic [TS_W-1:0]  ts_acc;
  logic [SEQ_W-1:0] seq;

  logic [LEN_W-1:0] nal_len;
  logic [LEN_W-1:0] rem;
  logic [LEN_W-1:0] offset;
  logic             first;
  logic             fu;
  logic [2:0]       hi_bits;
  logic [4:0]       typ;

  logic [LEN_W-1:0] in_len;
  logic             frag_last;

  logic [SEQ_W-1:0]  o_seq;
  logic [TS_W-1:0]   o_ts;
  logic              o_marker;
  logic [7:0]        o_ind;
  logic              o_has_fu;
  logic [7:0]        o_fuh;
  logic [LEN_W-1:0]  o_off;
  logic [PLEN_W-1:0] o_plen;
  logic [PLEN_W-1:0] o_pkt;
  logic              o_last;

  logic [PLEN_W-1:0] fu_plen;

  assign in_len      = s_tdata[15:0];
  assign frag_last   = (rem < FRAG_LEN);
  assign status.done = !fu || frag_last;
  assign fu_plen     = frag_last ? rem[PLEN_W-1:0] : FRAG_PLEN;

  always_ff @(posedge clk) begin
    if (rst) begin
      ts_increment <= TS_INC_RESET;
      ts_acc       <= '0;
      seq          <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TS_INCREMENT: ts_increment <= cfg_data;
          REG_PAYLOAD_TYPE, REG_SSRC: ;
          default: ;
        endcase
      end
      if (cmd.load) ts_acc <= ts_acc + ts_increment;
      if (cmd.emit) seq <= seq + SEQ_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      nal_len <= in_len;
      rem     <= (in_len == '0) ? '0 : in_len - LEN_W'(1);
      offset  <= LEN_W'(1);
      first   <= 1'b1;
      fu      <= (in_len > FRAG_LEN);
      hi_bits <= s_tdata[18:16];
      typ     <= s_tdata[23:19];
    end else if (cmd.emit) begin
      rem    <= rem - FRAG_LEN;
      offset <= offset + FRAG_LEN;
      first  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_seq <= seq;
      o_ts  <= ts_acc;
      if (fu) begin
        o_marker <= frag_last;
        o_ind    <= {hi_bits[0], hi_bits[2:1], FU_A_TYPE};
        o_has_fu <= 1'b1;
        o_fuh    <= {first, frag_last, 1'b0, typ};
        o_off    <= offset;
        o_plen   <= fu_plen;
        o_pkt    <= fu_plen + HDR_LEN_FU_A;
        o_last   <= frag_last;
      end else begin
        o_marker <= 1'b1;
        o_ind    <= {hi_bits[0], hi_bits[2:1], typ};
        o_has_fu <= 1'b0;
        o_fuh    <= '0;
        o_off    <= LEN_W'(1);
        o_plen   <= rem[PLEN_W-1:0];
        o_pkt    <= nal_len[PLEN_W-1:0] + HDR_LEN_SINGLE;
        o_last   <= 1'b1;
      end
    end
  end

  assign m_tdata = {1'b0, o_pkt, o_plen, o_off, o_fuh, o_ind, o_marker, o_ts, o_seq};
  assign m_tuser = o_has_fu;
  assign m_tlast = o_last;

endmodule

FILE: rtl/rtp_h264_packetizer_unit.sv
// H.264 RTP packetizer: NAL unit descriptors in, RTP packet descriptors out.
// Input stream (s_*): one transaction per NAL unit; tdata holds nal_length,
// f_bit, ref_idc and nal_type. Each accepted NAL advances the RTP
// timestamp by ts_increment.
// Output stream (m_*): one transaction per packet. A NAL of up to 1400 bytes
// yields one single NAL unit packet; a longer one yields (len-1)/1400+1 FU-A
// fragments. tlast marks the last packet of a NAL, tuser marks FU-A.
// Configuration: cfg_we/cfg_index/cfg_data, index 0 ts_increment,
// 1 payload_type, 2 ssrc; write only while the block is idle.
// Timing: a NAL is taken while the block is idle, then its packets leave one per
// cycle from the output register while m_tready is high; s_tready stays low
// until the last packet of the NAL is in the output register. The fragment
// sequencer sets this pace. A stall on m_tready holds the current packet and
// freezes the sequencer.
// Reset clears sequence number and timestamp to 0, restores the register
// defaults and empties the output register.
module rtp_h264_packetizer_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // nal_length[15:0], f_bit[16], ref_idc[18:17], nal_type[23:19]
  input  logic [rtpk_pkg::S_DATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // seq_number[15:0], rtp_timestamp[47:16], marker[48], indicator_byte[56:49],
  // fu_header_byte[64:57], payload_offset[80:65], payload_length[91:81],
  // packet_length[102:92], zero pad[103]
  output logic [rtpk_pkg::M_DATA_W-1:0] m_tdata,
  // has_fu_header[0]
  output logic                          m_tuser,
  output logic                          m_tlast,
  input  logic                          cfg_we,
  input  logic [rtpk_pkg::IDX_W-1:0]    cfg_index,
  input  logic [rtpk_pkg::CFG_W-1:0]    cfg_data
);
  import rtpk_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  rtpk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rtpk_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

FILE: rtl/rtpk_checker.sv
module rtpk_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [rtpk_pkg::M_DATA_W-1:0] m_tdata,
  input logic                          m_tlast
);
  import rtpk_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !rst && m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output transaction changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    !rst && s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while NAL in progress");

  a_seq: assert property (@(posedge clk) disable iff (rst)
    !rst && m_tvalid && m_tready && !m_tlast |=>
      m_tvalid && (m_tdata[15:0] == $past(m_tdata[15:0]) + 16'd1))
    else $error("fragment sequence broken");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not idle after reset");

endmodule

bind rtp_h264_packetizer_unit rtpk_checker u_rtpk_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
